// ===== rtl/sit_pkg.sv =====
// shared widths, constants and types for the segment intersection pipeline
package sit_pkg;

    localparam int FIELD_W = 16;        // width of one input coordinate field
    localparam int CW      = 17;        // coordinate after extraction, signed
    localparam int DW      = 18;        // coordinate difference, signed
    localparam int XW      = 36;        // product of two differences
    localparam int CPW     = 37;        // cross product
    localparam int LOW     = 19;        // low slice of a cross product for split multiplies
    localparam int PPW     = 40;        // partial product width
    localparam int NUMW    = 60;        // numerator, signed
    localparam int MW      = 59;        // numerator magnitude
    localparam int RW      = 38;        // divider partial remainder
    localparam int QB_BASE = 18;        // quotient bits above the fraction
    localparam int OUT_W   = 24;        // output point width

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    typedef struct packed {
        logic [FIELD_W-1:0] a_x;
        logic [FIELD_W-1:0] a_y;
        logic [FIELD_W-1:0] b_x;
        logic [FIELD_W-1:0] b_y;
        logic [FIELD_W-1:0] c_x;
        logic [FIELD_W-1:0] c_y;
        logic [FIELD_W-1:0] d_x;
        logic [FIELD_W-1:0] d_y;
    } t_seg;

    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
    } t_ctl;

endpackage

// ===== rtl/sit_front.sv =====
// front stages: coordinate extraction, differences, cross products, hit decision
module sit_front import sit_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_seg                  i_seg,
    output t_ctl                  o_ctl,
    output logic signed [CW-1:0]  o_ax,
    output logic signed [CW-1:0]  o_ay,
    output logic signed [DW-1:0]  o_rx,
    output logic signed [DW-1:0]  o_ry,
    output logic [CPW-1:0]        o_den,
    output logic [CPW-1:0]        o_tn
);

    localparam int EB = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;

    function automatic logic signed [CW-1:0] take(input logic [FIELD_W-1:0] f);
        logic signed [FIELD_W-1:0] t;
        t = $signed(f << (FIELD_W - EB)) >>> (FIELD_W - EB);
        if (COORD_BITS > FIELD_W) begin
            take = $signed({1'b0, f});
        end else begin
            take = CW'(t);
        end
    endfunction

    // stage 1
    logic                  r_v1;
    logic signed [CW-1:0]  r1_ax, r1_ay;
    logic signed [DW-1:0]  r1_rx, r1_ry, r1_sx, r1_sy, r1_wx, r1_wy;
    // stage 2
    logic                  r_v2;
    logic signed [CW-1:0]  r2_ax, r2_ay;
    logic signed [DW-1:0]  r2_rx, r2_ry;
    logic signed [XW-1:0]  r2_rsy, r2_rysx, r2_wsy, r2_wysx, r2_wry, r2_wyrx;
    // stage 3
    logic                  r_v3;
    logic signed [CW-1:0]  r3_ax, r3_ay;
    logic signed [DW-1:0]  r3_rx, r3_ry;
    logic signed [CPW-1:0] r3_den, r3_tn, r3_un;
    // stage 4
    logic                  r_v4, r4_hit;
    logic signed [CW-1:0]  r4_ax, r4_ay;
    logic signed [DW-1:0]  r4_rx, r4_ry;
    logic [CPW-1:0]        r4_den, r4_tn;

    logic signed [CW-1:0]  n_ax, n_ay, n_bx, n_by, n_cx, n_cy, n_dx, n_dy;
    logic signed [CPW-1:0] n_den, n_tn, n_un;
    logic                  n_hit;

    always_comb begin
        n_ax = take(i_seg.a_x);
        n_ay = take(i_seg.a_y);
        n_bx = take(i_seg.b_x);
        n_by = take(i_seg.b_y);
        n_cx = take(i_seg.c_x);
        n_cy = take(i_seg.c_y);
        n_dx = take(i_seg.d_x);
        n_dy = take(i_seg.d_y);
    end

    // sign normalisation to a non-negative denominator, then the hit decision
    always_comb begin
        n_den = r3_den[CPW-1] ? -r3_den : r3_den;
        n_tn  = r3_den[CPW-1] ? -r3_tn  : r3_tn;
        n_un  = r3_den[CPW-1] ? -r3_un  : r3_un;
        n_hit = (r3_den != '0) && !n_tn[CPW-1] && (n_tn <= n_den)
                && !n_un[CPW-1] && (n_un <= n_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax   <= n_ax;
            r1_ay   <= n_ay;
            r1_rx   <= DW'(n_bx) - DW'(n_ax);
            r1_ry   <= DW'(n_by) - DW'(n_ay);
            r1_sx   <= DW'(n_dx) - DW'(n_cx);
            r1_sy   <= DW'(n_dy) - DW'(n_cy);
            r1_wx   <= DW'(n_cx) - DW'(n_ax);
            r1_wy   <= DW'(n_cy) - DW'(n_ay);

            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_rx   <= r1_rx;
            r2_ry   <= r1_ry;
            r2_rsy  <= r1_rx * r1_sy;
            r2_rysx <= r1_ry * r1_sx;
            r2_wsy  <= r1_wx * r1_sy;
            r2_wysx <= r1_wy * r1_sx;
            r2_wry  <= r1_wx * r1_ry;
            r2_wyrx <= r1_wy * r1_rx;

            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_rx   <= r2_rx;
            r3_ry   <= r2_ry;
            r3_den  <= CPW'(r2_rsy) - CPW'(r2_rysx);
            r3_tn   <= CPW'(r2_wsy) - CPW'(r2_wysx);
            r3_un   <= CPW'(r2_wry) - CPW'(r2_wyrx);

            r4_ax   <= r3_ax;
            r4_ay   <= r3_ay;
            r4_rx   <= r3_rx;
            r4_ry   <= r3_ry;
            r4_den  <= n_den;
            r4_tn   <= n_tn;
            r4_hit  <= n_hit;
        end
    end

    assign o_ctl.valid = r_v4;
    assign o_ctl.hit   = r4_hit;
    assign o_ctl.neg_x = 1'b0;
    assign o_ctl.neg_y = 1'b0;
    assign o_ax  = r4_ax;
    assign o_ay  = r4_ay;
    assign o_rx  = r4_rx;
    assign o_ry  = r4_ry;
    assign o_den = r4_den;
    assign o_tn  = r4_tn;

endmodule

// ===== rtl/sit_num.sv =====
// numerator stages: split multiplies, sum, magnitude and divider set-up
module sit_num import sit_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int QB = QB_BASE + FRAC_BITS,
    localparam int AW = RW + QB
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_ctl                  i_ctl,
    input  logic signed [CW-1:0]  i_ax,
    input  logic signed [CW-1:0]  i_ay,
    input  logic signed [DW-1:0]  i_rx,
    input  logic signed [DW-1:0]  i_ry,
    input  logic [CPW-1:0]        i_den,
    input  logic [CPW-1:0]        i_tn,
    output t_ctl                  o_ctl,
    output logic [CPW-1:0]        o_den,
    output logic [AW-1:0]         o_acc_x,
    output logic [AW-1:0]         o_acc_y
);

    localparam int SW = MW + FRAC_BITS;

    t_ctl                   r5_ctl, r6_ctl, r7_ctl;
    logic [CPW-1:0]         r5_den, r6_den, r7_den;
    logic signed [PPW-1:0]  r5_axl, r5_axh, r5_rxl, r5_rxh;
    logic signed [PPW-1:0]  r5_ayl, r5_ayh, r5_ryl, r5_ryh;
    logic signed [NUMW-1:0] r6_nx, r6_ny;
    logic [AW-1:0]          r7_ax, r7_ay;

    logic signed [LOW:0]       n_dlo, n_tlo;
    logic signed [CPW-LOW:0]   n_dhi, n_thi;
    logic signed [NUMW-1:0]    n_nx, n_ny, n_mx, n_my;
    logic [SW-1:0]             n_sx, n_sy;

    always_comb begin
        n_dlo = $signed({1'b0, i_den[LOW-1:0]});
        n_dhi = $signed({1'b0, i_den[CPW-1:LOW]});
        n_tlo = $signed({1'b0, i_tn[LOW-1:0]});
        n_thi = $signed({1'b0, i_tn[CPW-1:LOW]});
        n_nx  = (NUMW'(r5_axh) <<< LOW) + NUMW'(r5_axl)
              + (NUMW'(r5_rxh) <<< LOW) + NUMW'(r5_rxl);
        n_ny  = (NUMW'(r5_ayh) <<< LOW) + NUMW'(r5_ayl)
              + (NUMW'(r5_ryh) <<< LOW) + NUMW'(r5_ryl);
        n_mx  = r6_nx[NUMW-1] ? -r6_nx : r6_nx;
        n_my  = r6_ny[NUMW-1] ? -r6_ny : r6_ny;
        // scale by the fraction; the quotient window drops the top bits
        n_sx  = SW'(n_mx[MW-1:0]) << FRAC_BITS;
        n_sy  = SW'(n_my[MW-1:0]) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctl.valid <= 1'b0;
            r6_ctl.valid <= 1'b0;
            r7_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r5_ctl <= i_ctl;
            r6_ctl <= r5_ctl;
            r7_ctl <= '{valid: r6_ctl.valid, hit: r6_ctl.hit,
                        neg_x: r6_nx[NUMW-1], neg_y: r6_ny[NUMW-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_den <= i_den;
            r5_axl <= i_ax * n_dlo;
            r5_axh <= i_ax * n_dhi;
            r5_rxl <= i_rx * n_tlo;
            r5_rxh <= i_rx * n_thi;
            r5_ayl <= i_ay * n_dlo;
            r5_ayh <= i_ay * n_dhi;
            r5_ryl <= i_ry * n_tlo;
            r5_ryh <= i_ry * n_thi;
            r6_den <= r5_den;
            r6_nx  <= n_nx;
            r6_ny  <= n_ny;
            r7_den <= r6_den;
            r7_ax  <= n_sx[AW-1:0];
            r7_ay  <= n_sy[AW-1:0];
        end
    end

    assign o_ctl   = r7_ctl;
    assign o_den   = r7_den;
    assign o_acc_x = r7_ax;
    assign o_acc_y = r7_ay;

endmodule

// ===== rtl/sit_div.sv =====
// pipelined restoring divider, one quotient bit per stage, x and y side by side
module sit_div import sit_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int QB = QB_BASE + FRAC_BITS,
    localparam int AW = RW + QB
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  t_ctl            i_ctl,
    input  logic [CPW-1:0]  i_den,
    input  logic [AW-1:0]   i_acc_x,
    input  logic [AW-1:0]   i_acc_y,
    output t_ctl            o_ctl,
    output logic [QB-1:0]   o_q_x,
    output logic [QB-1:0]   o_q_y
);

    function automatic logic [AW-1:0] step(input logic [AW-1:0] acc,
                                           input logic [CPW-1:0] den);
        logic [AW-1:0] sh;
        logic [RW:0]   trial;
        sh    = {acc[AW-2:0], 1'b0};
        trial = {1'b0, sh[AW-1:QB]} - (RW+1)'(den);
        if (!trial[RW]) begin
            step = {trial[RW-1:0], sh[QB-1:1], 1'b1};
        end else begin
            step = sh;
        end
    endfunction

    t_ctl           r_ctl [QB];
    logic [CPW-1:0] r_den [QB];
    logic [AW-1:0]  r_ax  [QB];
    logic [AW-1:0]  r_ay  [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        t_ctl           s_ctl;
        logic [CPW-1:0] s_den;
        logic [AW-1:0]  s_ax, s_ay;

        if (k == 0) begin : g_first
            assign s_ctl = i_ctl;
            assign s_den = i_den;
            assign s_ax  = i_acc_x;
            assign s_ay  = i_acc_y;
        end else begin : g_next
            assign s_ctl = r_ctl[k-1];
            assign s_den = r_den[k-1];
            assign s_ax  = r_ax[k-1];
            assign s_ay  = r_ay[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k].valid <= 1'b0;
            end else if (i_en) begin
                r_ctl[k] <= s_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= s_den;
                r_ax[k]  <= step(s_ax, s_den);
                r_ay[k]  <= step(s_ay, s_den);
            end
        end
    end

    assign o_ctl = r_ctl[QB-1];
    assign o_q_x = r_ax[QB-1][QB-1:0];
    assign o_q_y = r_ay[QB-1][QB-1:0];

endmodule

// ===== rtl/segment_intersection_test.sv =====
// segment intersection test: top level with output register and stall control
// data path: front, numerator and divider stages, then the output register
// one beat per cycle unless stalled; the quotient pipeline gives one bit per stage
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset is synchronous and active low; it clears every valid bit, data is not reset
module segment_intersection_test import sit_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [FIELD_W-1:0] i_a_x,
    input  logic signed [FIELD_W-1:0] i_a_y,
    input  logic signed [FIELD_W-1:0] i_b_x,
    input  logic signed [FIELD_W-1:0] i_b_y,
    input  logic signed [FIELD_W-1:0] i_c_x,
    input  logic signed [FIELD_W-1:0] i_c_y,
    input  logic signed [FIELD_W-1:0] i_d_x,
    input  logic signed [FIELD_W-1:0] i_d_y,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_hit,
    output logic signed [OUT_W-1:0]   o_meet_x,
    output logic signed [OUT_W-1:0]   o_meet_y
);

    localparam int QB = QB_BASE + FRAC_BITS;
    localparam int AW = RW + QB;
    localparam int EW = QB + OUT_W;     // room for the signed quotient before the cut

    // pipeline advances whenever the output register is free or being drained
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    t_seg seg;
    assign seg = '{a_x: i_a_x, a_y: i_a_y, b_x: i_b_x, b_y: i_b_y,
                   c_x: i_c_x, c_y: i_c_y, d_x: i_d_x, d_y: i_d_y};

    // front: differences, cross products, normalised sign and hit flag
    t_ctl                  f_ctl;
    logic signed [CW-1:0]  f_ax, f_ay;
    logic signed [DW-1:0]  f_rx, f_ry;
    logic [CPW-1:0]        f_den, f_tn;

    sit_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_seg   (seg),
        .o_ctl   (f_ctl),
        .o_ax    (f_ax),
        .o_ay    (f_ay),
        .o_rx    (f_rx),
        .o_ry    (f_ry),
        .o_den   (f_den),
        .o_tn    (f_tn)
    );

    // numerators a*den + r*tn, their magnitudes and the divider start value
    t_ctl           m_ctl;
    logic [CPW-1:0] m_den;
    logic [AW-1:0]  m_acc_x, m_acc_y;

    sit_num #(.FRAC_BITS(FRAC_BITS)) u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (f_ctl),
        .i_ax    (f_ax),
        .i_ay    (f_ay),
        .i_rx    (f_rx),
        .i_ry    (f_ry),
        .i_den   (f_den),
        .i_tn    (f_tn),
        .o_ctl   (m_ctl),
        .o_den   (m_den),
        .o_acc_x (m_acc_x),
        .o_acc_y (m_acc_y)
    );

    // magnitude quotients, both coordinates share the denominator
    t_ctl          d_ctl;
    logic [QB-1:0] d_q_x, d_q_y;

    sit_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (m_ctl),
        .i_den   (m_den),
        .i_acc_x (m_acc_x),
        .i_acc_y (m_acc_y),
        .o_ctl   (d_ctl),
        .o_q_x   (d_q_x),
        .o_q_y   (d_q_y)
    );

    // restore the sign (truncation toward zero), zero the point on a miss
    logic [EW-1:0] n_sx, n_sy;
    always_comb begin
        n_sx = d_ctl.neg_x ? -EW'(d_q_x) : EW'(d_q_x);
        n_sy = d_ctl.neg_y ? -EW'(d_q_y) : EW'(d_q_y);
    end

    logic                    r_valid, r_hit;
    logic signed [OUT_W-1:0] r_mx, r_my;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= d_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= d_ctl.hit;
            r_mx  <= d_ctl.hit ? $signed(n_sx[OUT_W-1:0]) : '0;
            r_my  <= d_ctl.hit ? $signed(n_sy[OUT_W-1:0]) : '0;
        end
    end

    assign o_valid  = r_valid;
    assign o_hit    = r_hit;
    assign o_meet_x = r_mx;
    assign o_meet_y = r_my;

`ifndef SYNTHESIS
    // a miss never carries a point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> (o_meet_x == '0) && (o_meet_y == '0))
        else $error("point not zero on a miss");

    // a result held back by the sink is still there next cycle
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_meet_x) && $stable(o_meet_y))
        else $error("stalled result lost or changed");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule
